@@ hw/rtl/rlmpd_pkg.sv @@
// Package for the RGB LED mode pattern driver.
// Holds field widths, register reset values, mode codes and register indexes.
// No dependencies.
`default_nettype none

package rlmpd_pkg;

  localparam int DutyW      = 8;
  localparam int ModeW      = 2;
  localparam int CodeW      = 7;
  localparam int PhaseW     = 2;
  localparam int FadeIntW   = 8;
  localparam int FlashIntW  = 10;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 10;

  typedef logic [DutyW-1:0]     duty_t;
  typedef logic [ModeW-1:0]     mode_t;
  typedef logic [CodeW-1:0]     code_t;
  typedef logic [PhaseW-1:0]    phase_t;
  typedef logic [FadeIntW-1:0]  fade_cnt_t;
  typedef logic [FlashIntW-1:0] flash_cnt_t;
  typedef logic [CfgIdxW-1:0]   cfg_idx_t;

  localparam duty_t      DUTY_MAX      = 8'd255;
  localparam code_t      BATTERY_CLAMP = 7'd98;
  localparam fade_cnt_t  FADE_CNT_MAX  = 8'd255;
  localparam flash_cnt_t FLASH_CNT_MAX = 10'd1023;
  localparam phase_t     PHASE_LAST    = 2'd2;

  localparam fade_cnt_t  FADE_INT_RST  = 8'd2;
  localparam flash_cnt_t FLASH_INT_RST = 10'd50;
  localparam code_t      RED_MAX_RST   = 7'd49;

  localparam mode_t MODE_OFF     = 2'd0;
  localparam mode_t MODE_FADE    = 2'd1;
  localparam mode_t MODE_BATTERY = 2'd2;
  localparam mode_t MODE_FLASH   = 2'd3;

  localparam cfg_idx_t REG_FADE_INT  = 2'd0;
  localparam cfg_idx_t REG_FLASH_INT = 2'd1;
  localparam cfg_idx_t REG_RED_MAX   = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/rgb_led_mode_pattern_driver.sv @@
// RGB LED mode pattern driver: tick counters, fade wheel and duty selection.
// Depends on rlmpd_pkg.
// Each accepted tick gives one result of blue, green and red duty in the next
// cycle from an output register; a tick is taken every cycle, and in_ready
// drops only while a finished result waits for out_ready. Both tick counters
// run on every transfer whatever the mode; duties hold until a mode rewrites
// them. Configuration writes take effect on the next transfer.
`default_nettype none

module rgb_led_mode_pattern_driver
  import rlmpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire mode_t               led_mode,
  input  wire code_t               battery_code,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      duty_t               blue_duty,
  output      duty_t               green_duty,
  output      duty_t               red_duty,
  input  wire logic                cfg_we,
  input  wire cfg_idx_t            cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  fade_cnt_t  fade_interval;
  flash_cnt_t flash_interval;
  code_t      battery_red_max;

  duty_t      fade_level, fade_level_next;
  phase_t     fade_phase, fade_phase_next;
  fade_cnt_t  fade_elapsed, fade_elapsed_next;
  flash_cnt_t flash_elapsed, flash_elapsed_next;
  logic       flash_lit, flash_lit_next;
  duty_t      blue_next, green_next, red_next;

  fade_cnt_t  fade_inc;
  flash_cnt_t flash_inc;
  duty_t      lvl_base, lvl_step;
  phase_t     phase_step;
  code_t      code_clamped;
  logic       xfer;

  assign in_ready = !out_valid || out_ready;
  assign xfer     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_interval   <= FADE_INT_RST;
      flash_interval  <= FLASH_INT_RST;
      battery_red_max <= RED_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FADE_INT:  fade_interval   <= cfg_data[FadeIntW-1:0];
        REG_FLASH_INT: flash_interval  <= cfg_data[FlashIntW-1:0];
        REG_RED_MAX:   battery_red_max <= cfg_data[CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fade_inc  = (fade_elapsed == FADE_CNT_MAX) ? fade_elapsed : fade_elapsed + 1'b1;
    flash_inc = (flash_elapsed == FLASH_CNT_MAX) ? flash_elapsed : flash_elapsed + 1'b1;

    // wrap the level and advance the phase at full scale
    lvl_base   = (fade_level == DUTY_MAX) ? '0 : fade_level;
    phase_step = fade_phase;
    if (fade_level == DUTY_MAX) begin
      phase_step = (fade_phase >= PHASE_LAST) ? '0 : fade_phase + 1'b1;
    end
    lvl_step = lvl_base + 1'b1;

    code_clamped = (battery_code > BATTERY_CLAMP) ? BATTERY_CLAMP : battery_code;

    fade_level_next    = fade_level;
    fade_phase_next    = fade_phase;
    fade_elapsed_next  = fade_inc;
    flash_elapsed_next = flash_inc;
    flash_lit_next     = flash_lit;
    blue_next          = blue_duty;
    green_next         = green_duty;
    red_next           = red_duty;

    case (led_mode)
      MODE_OFF: begin
        blue_next  = '0;
        green_next = '0;
        red_next   = '0;
      end
      MODE_FADE: begin
        if (fade_inc >= fade_interval) begin
          fade_elapsed_next = '0;
          fade_level_next   = lvl_step;
          fade_phase_next   = phase_step;
          case (phase_step)
            2'd0: begin
              blue_next  = ~lvl_step;
              green_next = lvl_step;
              red_next   = '0;
            end
            2'd1: begin
              blue_next  = '0;
              green_next = ~lvl_step;
              red_next   = lvl_step;
            end
            default: begin
              blue_next  = lvl_step;
              green_next = '0;
              red_next   = ~lvl_step;
            end
          endcase
        end
      end
      MODE_BATTERY: begin
        blue_next = '0;
        if (code_clamped <= battery_red_max) begin
          green_next = '0;
          red_next   = DUTY_MAX;
        end else begin
          green_next = DUTY_MAX;
          red_next   = '0;
        end
      end
      default: begin
        if (flash_inc >= flash_interval) begin
          flash_elapsed_next = '0;
          flash_lit_next     = !flash_lit;
        end
        blue_next  = '0;
        green_next = '0;
        red_next   = flash_lit_next ? DUTY_MAX : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_level    <= '0;
      fade_phase    <= '0;
      fade_elapsed  <= '0;
      flash_elapsed <= '0;
      flash_lit     <= 1'b0;
      blue_duty     <= '0;
      green_duty    <= '0;
      red_duty      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (xfer) begin
        fade_level    <= fade_level_next;
        fade_phase    <= fade_phase_next;
        fade_elapsed  <= fade_elapsed_next;
        flash_elapsed <= flash_elapsed_next;
        flash_lit     <= flash_lit_next;
        blue_duty     <= blue_next;
        green_duty    <= green_next;
        red_duty      <= red_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rlmpd_checker.sv @@
// Port-level checker for the RGB LED mode pattern driver, with its bind.
// Depends on rlmpd_pkg.
`default_nettype none

module rlmpd_checker
  import rlmpd_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire mode_t led_mode,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire duty_t blue_duty,
  input wire duty_t green_duty,
  input wire duty_t red_duty
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(blue_duty) &&
      $stable(green_duty) && $stable(red_duty))
    else $error("result changed while stalled");

  a_off: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && led_mode == MODE_OFF |=>
      out_valid && blue_duty == '0 && green_duty == '0 && red_duty == '0)
    else $error("off mode left a channel lit");

  a_battery: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && led_mode == MODE_BATTERY |=>
      out_valid && blue_duty == '0 &&
      ((red_duty == DUTY_MAX && green_duty == '0) ||
       (red_duty == '0 && green_duty == DUTY_MAX)))
    else $error("battery mode shows neither red nor green");

  a_flash: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && led_mode == MODE_FLASH |=>
      out_valid && blue_duty == '0 && green_duty == '0 &&
      (red_duty == '0 || red_duty == DUTY_MAX))
    else $error("flash mode duty out of pattern");

endmodule

bind rgb_led_mode_pattern_driver rlmpd_checker u_rlmpd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .led_mode   (led_mode),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .blue_duty  (blue_duty),
  .green_duty (green_duty),
  .red_duty   (red_duty)
);

`default_nettype wire

@@ tb/rgb_led_mode_pattern_driver_tb.sv @@
`timescale 1ns / 100ps
// Testbench for rgb_led_mode_pattern_driver: drives timer ticks and register writes,
// predicts the blue, green and red duties per tick and checks every transfer.
// Depends on rlmpd_pkg and the rgb_led_mode_pattern_driver RTL.

module rgb_led_mode_pattern_driver_tb
  import rlmpd_pkg::*;
;

  typedef struct packed {
    duty_t blue;
    duty_t green;
    duty_t red;
  } duty_set_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  mode_t               led_mode     = MODE_OFF;
  code_t               battery_code = '0;
  logic                out_valid;
  logic                out_ready    = 1'b1;
  duty_t               blue_duty;
  duty_t               green_duty;
  duty_t               red_duty;
  logic                cfg_we       = 1'b0;
  cfg_idx_t            cfg_index    = REG_FADE_INT;
  logic [CfgDataW-1:0] cfg_data     = '0;

  fade_cnt_t  cfg_fade_int  = FADE_INT_RST;
  flash_cnt_t cfg_flash_int = FLASH_INT_RST;
  code_t      cfg_red_max   = RED_MAX_RST;

  duty_t      fade_level    = '0;
  phase_t     fade_phase    = '0;
  fade_cnt_t  fade_elapsed  = '0;
  flash_cnt_t flash_elapsed = '0;
  logic       flash_lit     = 1'b0;
  duty_set_t  held_duties   = '0;

  duty_set_t duty_queue[$];
  int        fail_count = 0;
  int        burst_left = 0;
  int        gap_max    = 0;
  int        stall_pct  = 0;
  int        stall_left = 0;

  rgb_led_mode_pattern_driver u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .led_mode     (led_mode),
    .battery_code (battery_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .blue_duty    (blue_duty),
    .green_duty   (green_duty),
    .red_duty     (red_duty),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void step_led_model(mode_t m, code_t c);
    code_t clamped;
    clamped = (c > BATTERY_CLAMP) ? BATTERY_CLAMP : c;
    if (fade_elapsed != FADE_CNT_MAX) fade_elapsed = fade_elapsed + 1'b1;
    if (flash_elapsed != FLASH_CNT_MAX) flash_elapsed = flash_elapsed + 1'b1;
    case (m)
      MODE_OFF: begin
        held_duties = '0;
      end
      MODE_FADE: begin
        if (fade_elapsed >= cfg_fade_int) begin
          fade_elapsed = '0;
          if (fade_level == DUTY_MAX) begin
            fade_level = '0;
            if (fade_phase >= PHASE_LAST) fade_phase = '0;
            else fade_phase = fade_phase + 1'b1;
          end
          fade_level = fade_level + 1'b1;
          case (fade_phase)
            2'd0:    held_duties = '{DUTY_MAX - fade_level, fade_level, 8'd0};
            2'd1:    held_duties = '{8'd0, DUTY_MAX - fade_level, fade_level};
            default: held_duties = '{fade_level, 8'd0, DUTY_MAX - fade_level};
          endcase
        end
      end
      MODE_BATTERY: begin
        if (clamped <= cfg_red_max) held_duties = '{8'd0, 8'd0, DUTY_MAX};
        else held_duties = '{8'd0, DUTY_MAX, 8'd0};
      end
      default: begin
        if (flash_elapsed >= cfg_flash_int) begin
          flash_elapsed = '0;
          flash_lit     = ~flash_lit;
        end
        held_duties = flash_lit ? duty_set_t'{8'd0, 8'd0, DUTY_MAX} : duty_set_t'('0);
      end
    endcase
    duty_queue.push_back(held_duties);
  endfunction

  function automatic void check_field(string label, duty_t want, duty_t got);
    if (want !== got) begin
      $display("%0t: %s duty mismatch: expected %0d, actual %0d", $time, label, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    duty_set_t want;
    if (!rst && in_valid && in_ready) step_led_model(led_mode, battery_code);
    if (!rst && out_valid && out_ready) begin
      if (duty_queue.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual b=%0d g=%0d r=%0d",
                 $time, blue_duty, green_duty, red_duty);
        fail_count++;
      end else begin
        want = duty_queue.pop_front();
        check_field("blue", want.blue, blue_duty);
        check_field("green", want.green, green_duty);
        check_field("red", want.red, red_duty);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || stall_pct == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_tick(mode_t m, code_t c);
    if (gap_max > 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    led_mode     <= m;
    battery_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (duty_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(fade_cnt_t fade_int, flash_cnt_t flash_int, code_t red_max);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FADE_INT;
    cfg_data  <= CfgDataW'(fade_int);
    @(posedge clk);
    cfg_index <= REG_FLASH_INT;
    cfg_data  <= CfgDataW'(flash_int);
    @(posedge clk);
    cfg_index <= REG_RED_MAX;
    cfg_data  <= CfgDataW'(red_max);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_fade_int  = fade_int;
    cfg_flash_int = flash_int;
    cfg_red_max   = red_max;
    @(posedge clk);
  endtask

  function automatic code_t pick_code();
    case ($urandom_range(0, 3))
      0:       return cfg_red_max;
      1:       return cfg_red_max + 1'b1;
      default: return code_t'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic test_reset_defaults();
    gap_max   = 0;
    stall_pct = 0;
    send_tick(MODE_OFF, 7'd0);
    repeat (4) send_tick(MODE_FADE, 7'd0);
    send_tick(MODE_BATTERY, 7'd0);
    send_tick(MODE_BATTERY, 7'd49);
    send_tick(MODE_BATTERY, 7'd50);
    send_tick(MODE_BATTERY, 7'd98);
    send_tick(MODE_BATTERY, 7'd99);
    send_tick(MODE_BATTERY, 7'd127);
    send_tick(MODE_BATTERY, 7'h55);
    send_tick(MODE_BATTERY, 7'h2A);
    repeat (3) send_tick(MODE_FLASH, 7'd0);
    repeat (2) send_tick(MODE_FADE, 7'd127);
    send_tick(MODE_OFF, 7'd127);
  endtask

  task automatic test_zero_interval();
    wait_drain();
    write_regs('0, '0, '0);
    repeat (4) send_tick(MODE_FADE, 7'd0);
    repeat (4) send_tick(MODE_FLASH, 7'd0);
    send_tick(MODE_BATTERY, 7'd0);
    send_tick(MODE_BATTERY, 7'd1);
    repeat (2) send_tick(MODE_FLASH, 7'd127);
  endtask

  task automatic test_fade_wheel();
    wait_drain();
    write_regs(8'd1, flash_cnt_t'($urandom_range(5, 20)), 7'd60);
    gap_max   = 6;
    stall_pct = 30;
    repeat (780) send_tick(MODE_FADE, code_t'($urandom_range(0, 127)));
  endtask

  task automatic test_flash_interleave();
    wait_drain();
    write_regs(fade_cnt_t'($urandom_range(2, 6)), flash_cnt_t'($urandom_range(3, 12)),
               code_t'($urandom_range(0, 127)));
    gap_max   = 4;
    stall_pct = 20;
    for (int i = 0; i < 200; i++) begin
      if (i == 100) wait_drain();
      if ($urandom_range(0, 9) < 8) send_tick(MODE_FLASH, pick_code());
      else send_tick(mode_t'($urandom_range(0, 3)), pick_code());
    end
  endtask

  task automatic test_saturated_counters();
    wait_drain();
    write_regs(FADE_CNT_MAX, FLASH_CNT_MAX, 7'd127);
    gap_max   = 2;
    stall_pct = 5;
    repeat (520) send_tick($urandom_range(0, 1) ? MODE_BATTERY : MODE_OFF, pick_code());
    repeat (3) send_tick(MODE_FADE, pick_code());
    repeat (3) send_tick(MODE_FLASH, pick_code());
    repeat (4) send_tick(MODE_BATTERY, code_t'($urandom_range(0, 127)));
  endtask

  task automatic test_random_mix();
    code_t red_max;
    for (int round = 0; round < 4; round++) begin
      wait_drain();
      case (round)
        0:       red_max = 7'd98;
        1:       red_max = 7'd97;
        2:       red_max = 7'd0;
        default: red_max = code_t'($urandom_range(0, 127));
      endcase
      write_regs(fade_cnt_t'($urandom_range(0, 10)), flash_cnt_t'($urandom_range(0, 60)),
                 red_max);
      gap_max   = (round == 1) ? 0 : 8;
      stall_pct = (round == 2) ? 0 : 40;
      repeat (50) send_tick(mode_t'($urandom_range(0, 3)), pick_code());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_interval();
    test_fade_wheel();
    test_saturated_counters();
    test_flash_interleave();
    test_random_mix();
    wait_drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ rgb_led_mode_pattern_driver.f @@
hw/rtl/rlmpd_pkg.sv
hw/rtl/rgb_led_mode_pattern_driver.sv
hw/rtl/rlmpd_checker.sv
tb/rgb_led_mode_pattern_driver_tb.sv
